### hdl/assert_macros.svh
// Assertion macros shared by the RTL files that carry concurrent checks.
// No dependencies; include this file by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

### hdl/fpdc_pkg.sv
// Constants, types and lookup functions of the fractional PLL divider calculator.
// No dependencies; used by the fraction step and the top level.
package fpdc_pkg;

   localparam logic [21:0] BAND0_MAX = 22'd1075000;
   localparam logic [21:0] BAND1_MAX = 22'd1228000;
   localparam logic [21:0] BAND2_MAX = 22'd1433000;
   localparam logic [21:0] BAND3_MAX = 22'd1720000;

   localparam logic [27:0] RECIP27 = 28'd159072863;
   localparam logic [5:0] RECIP27_SHIFT = 6'd32;
   localparam logic [30:0] SCALE_QUOT = 31'd37;
   localparam logic [31:0] RECIP_MEGA = 32'd2251799814;
   localparam logic [30:0] MEGA = 31'd1000000;
   localparam logic [20:0] RECIP_TEN20 = 21'd1677722;
   localparam logic [28:0] RECIP_TEN29 = 29'd429496730;
   localparam logic [28:0] FRAC_LIMIT = 29'h0FFFFFFF;
   localparam logic [12:0] NMIN = 13'd131;
   localparam logic [12:0] NMAX = 13'd251;
   localparam logic [7:0] LO_FIXED = 8'b0001_1110;
   localparam logic [7:0] LO_ENABLES = 8'hE1;
   localparam logic [7:0] DSM_OFFSET = 8'd128;
   localparam int NUM_STEPS = 15;

   typedef struct packed {
      logic [2:0] band;
      logic ok;
      logic ref3;
      logic predivider;
      logic [7:0] dsm_integer;
   } meta_type;

   function automatic logic in_window(input logic [12:0] n);
      return (n >= NMIN) && (n <= NMAX);
   endfunction

   function automatic logic [7:0] lo_config_of(input logic [2:0] band);
      case (band)
         3'd0: return LO_FIXED;
         3'd1, 3'd2, 3'd3, 3'd4: return LO_FIXED | LO_ENABLES;
         default: return 8'd0;
      endcase
   endfunction

   function automatic logic [7:0] div_select_of(input logic [2:0] band);
      case (band)
         3'd0: return 8'h04;
         3'd1: return 8'hA8;
         3'd2: return 8'h28;
         3'd3: return 8'h88;
         3'd4: return 8'h08;
         default: return 8'd0;
      endcase
   endfunction

   // Reciprocal of the remaining power of ten, indexed by the number of rescalings.
   function automatic logic [29:0] recip_mult(input logic [3:0] ndiv);
      case (ndiv)
         4'd0: return 30'd562949954;
         4'd1: return 30'd703687442;
         4'd2: return 30'd879609303;
         4'd3: return 30'd549755814;
         4'd4: return 30'd687194768;
         4'd5: return 30'd858993460;
         default: return 30'd1;
      endcase
   endfunction

   function automatic logic [5:0] recip_shift(input logic [3:0] ndiv);
      case (ndiv)
         4'd0: return 6'd49;
         4'd1: return 6'd46;
         4'd2: return 6'd43;
         4'd3: return 6'd39;
         4'd4: return 6'd36;
         4'd5: return 6'd33;
         default: return 6'd0;
      endcase
   endfunction

endpackage

### hdl/fpdc_req_if.sv
// Request channel carrying the tuning frequency.
// Depends on nothing but the valid/ready convention of the block.
interface fpdc_req_if;
   logic valid;
   logic ready;
   logic [21:0] freq_khz;

   modport source(output valid, freq_khz, input ready);
   modport sink(input valid, freq_khz, output ready);
endinterface

### hdl/fpdc_rsp_if.sv
// Response channel carrying the synthesizer words.
// Depends on nothing but the valid/ready convention of the block.
interface fpdc_rsp_if;
   logic valid;
   logic ready;
   logic range_error;
   logic [2:0] band;
   logic [7:0] lo_config;
   logic [7:0] divider_select;
   logic [1:0] ref_ratio;
   logic predivider;
   logic [7:0] dsm_integer;
   logic [15:0] dsm_fraction;

   modport source(output valid, range_error, band, lo_config, divider_select,
                  ref_ratio, predivider, dsm_integer, dsm_fraction, input ready);
   modport sink(input valid, range_error, band, lo_config, divider_select,
                ref_ratio, predivider, dsm_integer, dsm_fraction, output ready);
endinterface

### hdl/fractional_pll_divider_calc_core.sv
// Top level of the fractional PLL divider calculator: a 26-stage pipeline.
// Depends on fpdc_pkg, fpdc_req_if, fpdc_rsp_if, fpdc_frac_step and assert_macros.svh.
//
// Each request carries a tuning frequency in kHz. The response gives the band,
// the LO chain enables, the divider selects, the reference ratio and predivider
// codes, and the integer and fractional synthesizer words, or a range error
// with every other field zero.
// One request enters in every cycle unless every stage is full and the receiver
// stalls; the 26 register stages each have at most one multiply on any path
// (scaling by the crystal, the two reciprocal divisions by one million, the
// fifteen doublings with rescaling and the final power-of-ten division).
// When the receiver stalls, the last stage holds its response and the stages
// behind it keep moving until they fill; empty stages still take requests.
// Synchronous reset empties every stage; no state survives across requests.
`include "assert_macros.svh"

module fractional_pll_divider_calc_core (
   input  logic clock,
   input  logic reset,
   fpdc_req_if.sink req_chan,
   fpdc_rsp_if.source rsp_chan
);

   localparam int NSTAGES = 26;
   localparam int FIRST_STEP = 9;
   localparam int FINAL_MULT = FIRST_STEP + fpdc_pkg::NUM_STEPS;
   localparam int OUT_STAGE = FINAL_MULT + 1;

   localparam logic [1:0] SHIFT_ZERO = 2'd0;
   localparam logic [1:0] SHIFT_ONE = 2'd1;
   localparam logic [1:0] SHIFT_TWO = 2'd2;

   logic [NSTAGES-1:0] vld_ff;
   logic [NSTAGES-1:0] vld_in;
   logic [NSTAGES-1:0] en;

   always_comb begin
      for (int i = 0; i < NSTAGES; i++) begin
         en[i] = rsp_chan.ready || !(&(vld_ff | ((NSTAGES'(1) << i) - NSTAGES'(1))));
         vld_in[i] = (i == 0) ? req_chan.valid : vld_ff[(i == 0) ? 0 : i - 1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         for (int i = 0; i < NSTAGES; i++) begin
            if (en[i]) begin
               vld_ff[i] <= vld_in[i];
            end
         end
      end
   end

   assign req_chan.ready = en[0];

   // Band selection and frequency times (8 - band).
   logic [2:0] band_in;
   logic [3:0] mult_in;
   logic [24:0] y_in;
   logic [2:0] band0_ff;
   logic [24:0] y0_ff;

   always_comb begin
      if (req_chan.freq_khz <= fpdc_pkg::BAND0_MAX) begin
         band_in = 3'd0;
      end else if (req_chan.freq_khz <= fpdc_pkg::BAND1_MAX) begin
         band_in = 3'd1;
      end else if (req_chan.freq_khz <= fpdc_pkg::BAND2_MAX) begin
         band_in = 3'd2;
      end else if (req_chan.freq_khz <= fpdc_pkg::BAND3_MAX) begin
         band_in = 3'd3;
      end else begin
         band_in = 3'd4;
      end
   end

   assign mult_in = 4'd8 - {1'b0, band_in};
   assign y_in = 25'(mult_in) * 25'(req_chan.freq_khz);

   always_ff @(posedge clock) begin
      if (en[0]) begin
         band0_ff <= band_in;
         y0_ff <= y_in;
      end
   end

   // Scaling by 1000/27, split as 37*y plus y/27.
   logic [52:0] p27;
   logic [20:0] hi27_ff;
   logic [30:0] y37_ff;
   logic [2:0] band1_ff;

   assign p27 = 53'(y0_ff) * 53'(fpdc_pkg::RECIP27);

   always_ff @(posedge clock) begin
      if (en[1]) begin
         hi27_ff <= 21'(p27 >> fpdc_pkg::RECIP27_SHIFT);
         y37_ff <= 31'(y0_ff) * fpdc_pkg::SCALE_QUOT;
         band1_ff <= band0_ff;
      end
   end

   logic [30:0] s2_ff;
   logic [2:0] band2_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_ff <= y37_ff + 31'(hi27_ff);
         band2_ff <= band1_ff;
      end
   end

   // Ratio V = S / 1000000.
   logic [62:0] pv;
   logic [10:0] v3_ff;
   logic [30:0] s3_ff;
   logic [2:0] band3_ff;

   assign pv = 63'(s2_ff) * 63'(fpdc_pkg::RECIP_MEGA);

   always_ff @(posedge clock) begin
      if (en[3]) begin
         v3_ff <= pv[61:51];
         s3_ff <= s2_ff;
         band3_ff <= band2_ff;
      end
   end

   // Reference multiplier and predivider shift selection.
   logic [12:0] vw;
   logic [12:0] vx3;
   logic r3_sel;
   logic [1:0] shift_sel;
   logic ok_sel;
   logic [30:0] k_in;
   fpdc_pkg::meta_type meta_in;
   logic [30:0] k4_ff;
   fpdc_pkg::meta_type meta4_ff;

   assign vw = 13'(v3_ff);
   assign vx3 = vw * 13'd3;

   always_comb begin
      r3_sel = 1'b0;
      shift_sel = SHIFT_ONE;
      ok_sel = 1'b1;
      if ((vw >> 1) < fpdc_pkg::NMIN) begin
         if (fpdc_pkg::in_window(vw)) begin
            shift_sel = SHIFT_ZERO;
         end else begin
            r3_sel = 1'b1;
            shift_sel = (vw > fpdc_pkg::NMAX) ? SHIFT_TWO : SHIFT_ONE;
            ok_sel = fpdc_pkg::in_window((vw > fpdc_pkg::NMAX) ? (vx3 >> 2) : (vx3 >> 1));
         end
      end else if ((vw >> 1) > fpdc_pkg::NMAX) begin
         shift_sel = SHIFT_TWO;
         r3_sel = (vw >> 2) > fpdc_pkg::NMAX;
         ok_sel = fpdc_pkg::in_window(((vw >> 2) > fpdc_pkg::NMAX) ? (vx3 >> 2) : (vw >> 2));
      end
   end

   always_comb begin
      case (shift_sel)
         SHIFT_ZERO: k_in = s3_ff;
         SHIFT_ONE: k_in = r3_sel ? (s3_ff >> 1) + s3_ff : s3_ff >> 1;
         SHIFT_TWO: k_in = r3_sel ? (s3_ff >> 1) + (s3_ff >> 2) : s3_ff >> 2;
         default: k_in = s3_ff;
      endcase
      meta_in.band = band3_ff;
      meta_in.ok = ok_sel;
      meta_in.ref3 = r3_sel;
      meta_in.predivider = shift_sel != SHIFT_ONE;
      meta_in.dsm_integer = 8'd0;
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         k4_ff <= k_in;
         meta4_ff <= meta_in;
      end
   end

   // Integer part and remainder of K / 1000000.
   logic [62:0] pq;
   logic [10:0] q5_ff;
   logic [30:0] k5_ff;
   fpdc_pkg::meta_type meta5_ff;

   assign pq = 63'(k4_ff) * 63'(fpdc_pkg::RECIP_MEGA);

   always_ff @(posedge clock) begin
      if (en[5]) begin
         q5_ff <= pq[61:51];
         k5_ff <= k4_ff;
         meta5_ff <= meta4_ff;
      end
   end

   logic [30:0] rem_full;
   fpdc_pkg::meta_type meta6_in;
   logic [19:0] rem6_ff;
   fpdc_pkg::meta_type meta6_ff;

   assign rem_full = k5_ff - 31'(q5_ff) * fpdc_pkg::MEGA;

   always_comb begin
      meta6_in = meta5_ff;
      meta6_in.dsm_integer = q5_ff[7:0] - fpdc_pkg::DSM_OFFSET;
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         rem6_ff <= rem_full[19:0];
         meta6_ff <= meta6_in;
      end
   end

   // Drop the last decimal digit of the remainder.
   logic [40:0] p10;
   logic [16:0] r10_7_ff;
   fpdc_pkg::meta_type meta7_ff;

   assign p10 = 41'(rem6_ff) * 41'(fpdc_pkg::RECIP_TEN20);

   always_ff @(posedge clock) begin
      if (en[7]) begin
         r10_7_ff <= p10[40:24];
         meta7_ff <= meta6_ff;
      end
   end

   logic [28:0] frac_chain [0:fpdc_pkg::NUM_STEPS];
   logic [3:0] ndiv_chain [0:fpdc_pkg::NUM_STEPS];
   fpdc_pkg::meta_type meta_chain [0:fpdc_pkg::NUM_STEPS];
   logic [28:0] frac8_ff;
   fpdc_pkg::meta_type meta8_ff;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         frac8_ff <= 29'(r10_7_ff) * 29'd10;
         meta8_ff <= meta7_ff;
      end
   end

   assign frac_chain[0] = frac8_ff;
   assign ndiv_chain[0] = 4'd0;
   assign meta_chain[0] = meta8_ff;

   for (genvar j = 0; j < fpdc_pkg::NUM_STEPS; j++) begin : g_step
      fpdc_frac_step u_step (
         .clock     (clock),
         .load      (en[FIRST_STEP + j]),
         .prev_frac (frac_chain[j]),
         .prev_ndiv (ndiv_chain[j]),
         .prev_meta (meta_chain[j]),
         .frac_ff   (frac_chain[j + 1]),
         .ndiv_ff   (ndiv_chain[j + 1]),
         .meta_ff   (meta_chain[j + 1])
      );
   end

   // Last doubling and division by the remaining power of ten.
   logic [28:0] last_doubled;
   logic [58:0] pf;
   logic [58:0] pf_ff;
   logic [5:0] shift_ff;
   fpdc_pkg::meta_type metaf_ff;

   assign last_doubled = {frac_chain[fpdc_pkg::NUM_STEPS][27:0], 1'b0};
   assign pf = 59'(last_doubled) *
               59'(fpdc_pkg::recip_mult(ndiv_chain[fpdc_pkg::NUM_STEPS]));

   always_ff @(posedge clock) begin
      if (en[FINAL_MULT]) begin
         pf_ff <= pf;
         shift_ff <= fpdc_pkg::recip_shift(ndiv_chain[fpdc_pkg::NUM_STEPS]);
         metaf_ff <= meta_chain[fpdc_pkg::NUM_STEPS];
      end
   end

   logic [58:0] frac_quot;
   logic range_error_ff;
   logic [2:0] band_ff;
   logic [7:0] lo_config_ff;
   logic [7:0] divider_select_ff;
   logic [1:0] ref_ratio_ff;
   logic predivider_ff;
   logic [7:0] dsm_integer_ff;
   logic [15:0] dsm_fraction_ff;

   assign frac_quot = pf_ff >> shift_ff;

   always_ff @(posedge clock) begin
      if (en[OUT_STAGE]) begin
         range_error_ff <= !metaf_ff.ok;
         if (metaf_ff.ok) begin
            band_ff <= metaf_ff.band;
            lo_config_ff <= fpdc_pkg::lo_config_of(metaf_ff.band);
            divider_select_ff <= fpdc_pkg::div_select_of(metaf_ff.band);
            ref_ratio_ff <= metaf_ff.ref3 ? 2'd2 : 2'd0;
            predivider_ff <= metaf_ff.predivider;
            dsm_integer_ff <= metaf_ff.dsm_integer;
            dsm_fraction_ff <= frac_quot[15:0];
         end else begin
            band_ff <= 3'd0;
            lo_config_ff <= 8'd0;
            divider_select_ff <= 8'd0;
            ref_ratio_ff <= 2'd0;
            predivider_ff <= 1'b0;
            dsm_integer_ff <= 8'd0;
            dsm_fraction_ff <= 16'd0;
         end
      end
   end

   assign rsp_chan.valid = vld_ff[OUT_STAGE];
   assign rsp_chan.range_error = range_error_ff;
   assign rsp_chan.band = band_ff;
   assign rsp_chan.lo_config = lo_config_ff;
   assign rsp_chan.divider_select = divider_select_ff;
   assign rsp_chan.ref_ratio = ref_ratio_ff;
   assign rsp_chan.predivider = predivider_ff;
   assign rsp_chan.dsm_integer = dsm_integer_ff;
   assign rsp_chan.dsm_fraction = dsm_fraction_ff;

   `ASSERT_IMPLY(a_error_clears_fields, clock, reset,
      rsp_chan.valid && rsp_chan.range_error,
      rsp_chan.band == 3'd0 && rsp_chan.dsm_integer == 8'd0 && rsp_chan.dsm_fraction == 16'd0)
   `ASSERT_IMPLY(a_full_stall_blocks, clock, reset,
      (&vld_ff) && !rsp_chan.ready, !req_chan.ready)
   `ASSERT_NEXT(a_accept_fills_first, clock, reset,
      req_chan.valid && req_chan.ready, vld_ff[0])

endmodule

### hdl/fpdc_frac_step.sv
// One doubling step of the fraction word with optional rescaling by ten.
// Depends on fpdc_pkg for the limit, the reciprocal and the side-band struct.
module fpdc_frac_step (
   input  logic clock,
   input  logic load,
   input  logic [28:0] prev_frac,
   input  logic [3:0] prev_ndiv,
   input  fpdc_pkg::meta_type prev_meta,
   output logic [28:0] frac_ff,
   output logic [3:0] ndiv_ff,
   output fpdc_pkg::meta_type meta_ff
);

   logic [28:0] doubled;
   logic [57:0] product;
   logic take;
   logic [28:0] frac_in;
   logic [3:0] ndiv_in;

   assign doubled = {prev_frac[27:0], 1'b0};
   assign product = 58'(doubled) * 58'(fpdc_pkg::RECIP_TEN29);
   assign take = doubled > fpdc_pkg::FRAC_LIMIT;
   assign frac_in = take ? 29'(product[57:32]) : doubled;
   assign ndiv_in = prev_ndiv + 4'(take);

   always_ff @(posedge clock) begin
      if (load) begin
         frac_ff <= frac_in;
         ndiv_ff <= ndiv_in;
         meta_ff <= prev_meta;
      end
   end

endmodule

### tb/fpdc_checker.sv
// Checker for the fractional PLL divider calculator: watches both channels,
// predicts each response from the accepted frequency and compares. Depends on
// the two channel interfaces.
`timescale 1ns / 1ps

module fpdc_checker (
   input  logic clock,
   input  logic reset,
   fpdc_req_if req_chan,
   fpdc_rsp_if rsp_chan,
   output int   error_count,
   output int   pending_count
);

   typedef struct packed {
      logic        range_error;
      logic [2:0]  band;
      logic [7:0]  lo_config;
      logic [7:0]  divider_select;
      logic [1:0]  ref_ratio;
      logic        predivider;
      logic [7:0]  dsm_integer;
      logic [15:0] dsm_fraction;
   } synth_words_type;

   synth_words_type expected_words[$];

   function automatic logic window_ok(input logic [63:0] n);
      return n >= 64'd131 && n <= 64'd251;
   endfunction

   function automatic synth_words_type calc_synth_words(input logic [21:0] freq);
      synth_words_type w;
      logic [63:0] f, s, v, k, kint, frac;
      logic [2:0]  bd;
      int          r, p, e;
      logic        ok;
      w = '0;
      f = 64'(freq);
      r = 1;
      p = 1;
      e = 6;
      ok = 1'b1;
      if (f <= 64'd1075000) bd = 3'd0;
      else if (f <= 64'd1228000) bd = 3'd1;
      else if (f <= 64'd1433000) bd = 3'd2;
      else if (f <= 64'd1720000) bd = 3'd3;
      else bd = 3'd4;
      s = (64'(8 - bd) * f * 64'd1000) / 64'd27;
      v = s / 64'd1000000;
      if ((v >> 1) < 64'd131) begin
         if (window_ok(v)) begin
            r = 1;
            p = 0;
         end else begin
            r = 3;
            p = (v > 64'd251) ? 2 : 1;
            ok = window_ok((v * 3) >> p);
         end
      end else if ((v >> 1) > 64'd251) begin
         p = 2;
         r = ((v >> 2) > 64'd251) ? 3 : 1;
         ok = window_ok((v * r) >> p);
      end
      if (!ok) begin
         w.range_error = 1'b1;
         return w;
      end
      if (r == 1) k = (p == 0) ? s : (p == 1) ? s / 2 : s / 4;
      else k = (p == 1) ? s / 2 + s : s / 2 + s / 4;
      kint = (k / 10) * 10;
      frac = kint % 64'd1000000;
      for (int i = 0; i < 16; i++) begin
         frac = frac * 2;
         if (frac > 64'h0FFFFFFF && i != 15) begin
            frac = frac / 10;
            e--;
         end
      end
      for (int i = 0; i < e; i++) frac = frac / 10;
      w.band = bd;
      w.lo_config = (bd == 3'd0) ? 8'h1E : 8'hFF;
      case (bd)
         3'd0: w.divider_select = 8'h04;
         3'd1: w.divider_select = 8'hA8;
         3'd2: w.divider_select = 8'h28;
         3'd3: w.divider_select = 8'h88;
         default: w.divider_select = 8'h08;
      endcase
      w.ref_ratio = (r == 3) ? 2'd2 : 2'd0;
      w.predivider = (p == 1) ? 1'b0 : 1'b1;
      w.dsm_integer = 8'(kint / 64'd1000000 - 64'd128);
      w.dsm_fraction = frac[15:0];
      return w;
   endfunction

   assign pending_count = expected_words.size();

   always @(posedge clock) begin
      synth_words_type got, want;
      if (reset) begin
         error_count = 0;
      end else begin
         if (req_chan.valid && req_chan.ready)
            expected_words.push_back(calc_synth_words(req_chan.freq_khz));
         if (rsp_chan.valid && rsp_chan.ready) begin
            got = '{rsp_chan.range_error, rsp_chan.band, rsp_chan.lo_config,
                    rsp_chan.divider_select, rsp_chan.ref_ratio, rsp_chan.predivider,
                    rsp_chan.dsm_integer, rsp_chan.dsm_fraction};
            if (expected_words.size() == 0) begin
               $display("%0t: unexpected response %h", $realtime, got);
               error_count++;
            end else begin
               want = expected_words.pop_front();
               if (got !== want) begin
                  $display("%0t: mismatch expected %h actual %h", $realtime, want, got);
                  error_count++;
               end
            end
         end
      end
   end
endmodule

### tb/tb_fractional_pll_divider_calc_core.sv
// Testbench top for the fractional PLL divider calculator: drives frequencies with
// random gaps and stalls and gives the verdict. Depends on fpdc_checker and the RTL.
`timescale 1ns / 1ps

module tb_fractional_pll_divider_calc_core;
   logic clock;
   logic reset;
   int   error_count, pending_count, idle_cycles, sent;
   logic no_idle;
   logic [21:0] directed_freqs[$];

   fpdc_req_if req_chan();
   fpdc_rsp_if rsp_chan();

   fractional_pll_divider_calc_core u_top (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan));

   fpdc_checker u_checker (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .error_count(error_count), .pending_count(pending_count));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [21:0] pick_freq();
      case ($urandom_range(0, 9))
         0: return 22'($urandom);
         1, 2: return 22'($urandom_range(900000, 2200000));
         3: return 22'($urandom_range(0, 20000));
         4: return 22'($urandom_range(1070000, 1080000));
         5: return 22'($urandom_range(1715000, 1725000));
         default: return 22'($urandom_range(200000, 3000000));
      endcase
   endfunction

   always @(posedge clock) begin
      if (reset) rsp_chan.ready <= 1'b0;
      else rsp_chan.ready <= no_idle || ($urandom_range(0, 99) >= 8);
   end

   always @(posedge clock) begin
      if (reset || req_chan.valid && req_chan.ready || rsp_chan.valid && rsp_chan.ready)
         idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("tb_fractional_pll_divider_calc_core: errors");
         $finish;
      end
   end

   initial begin
      logic [21:0] next_freq;
      no_idle = 1'b0;
      req_chan.valid = 1'b0;
      req_chan.freq_khz = '0;
      reset = 1'b1;
      directed_freqs = '{22'd0, 22'h3FFFFF, 22'd1075000, 22'd1075001, 22'd1228000,
                         22'd1228001, 22'd1433000, 22'd1433001, 22'd1720000,
                         22'd1720001, 22'd950000, 22'd500000, 22'd300000,
                         22'd2000000, 22'd2150000, 22'd3000000, 22'd3500000,
                         22'd400000, 22'd1300000, 22'd1600000, 22'h2AAAAA,
                         22'h155555};
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      sent = 0;
      while (sent < 420) begin
         @(posedge clock);
         if (!req_chan.valid || req_chan.ready) begin
            no_idle <= (sent >= 150 && sent < 250);
            if (!(sent >= 150 && sent < 250) && $urandom_range(0, 99) < 8) begin
               req_chan.valid <= 1'b0;
            end else begin
               next_freq = (sent < directed_freqs.size()) ? directed_freqs[sent]
                                                          : pick_freq();
               req_chan.valid <= 1'b1;
               req_chan.freq_khz <= next_freq;
               sent++;
            end
         end
      end
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_count == 0)
         $display("tb_fractional_pll_divider_calc_core: clean");
      else
         $display("tb_fractional_pll_divider_calc_core: errors");
      $finish;
   end
endmodule
